FILE: rtl/core/mh64_pkg.sv
`default_nettype none
package mh64_pkg;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
   localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
   localparam int unsigned MIX_SHIFT = 47;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned NBYTE_W = 4;
   localparam int unsigned LEN_W   = 31;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN_MUL,
      ST_K_MUL1,
      ST_K_MUL2,
      ST_TAIL,
      ST_H_MUL,
      ST_FIN_MUL,
      ST_EMIT
   } mh64_state_type;

   // partial-product steps of the shared multiplier
   typedef enum logic [1:0] {
      MS_LO_LO,
      MS_HI_LO,
      MS_LO_HI,
      MS_SUM
   } mh64_mstep_type;

   // keep the low nbytes bytes of a word
   function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] nbytes);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(nbytes)) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mh64_if.sv
`default_nettype none
interface mh64_req_if;
   import mh64_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [NBYTE_W-1:0]  valid_bytes;
   logic                first;
   logic                last;
   logic [LEN_W-1:0]    total_length;

   modport source (output valid, data_word, valid_bytes, first, last, total_length,
                   input ready);
   modport sink   (input valid, data_word, valid_bytes, first, last, total_length,
                   output ready);
endinterface

interface mh64_rsp_if;
   import mh64_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

interface mh64_csr_if;
   import mh64_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/murmur2_64bit_stream_hash.sv
`default_nettype none
// Channel   Dir  Handshake      Beat contents
// req_chan  in   valid/ready    data_word, valid_bytes, first, last, total_length
// rsp_chan  out  valid/ready    hash_value (one beat per message, after last)
// csr_chan  in   valid/ready    data = seed (always ready)
//
// One 32x32 multiplier is shared by every 64-bit multiply by the mix constant.
// Per req beat: accept in ST_IDLE, ST_LEN_MUL if first, ST_K_MUL1, ST_K_MUL2
// and ST_H_MUL for a full word or ST_TAIL and ST_H_MUL for a tail, ST_FIN_MUL
// if last, and ST_EMIT to hand off the hash (it waits while rsp is stalled).
// Reset: synchronous, active high; clears seed and running hash to zero.
// rsp is registered: a new req beat is taken while a hash waits on rsp.
module murmur2_64bit_stream_hash
   import mh64_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mh64_req_if.sink   req_chan,
   mh64_rsp_if.source rsp_chan,
   mh64_csr_if.sink   csr_chan
);

   mh64_state_type     state_ff, state_in;

   // latched request beat
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [NBYTE_W-1:0] nbytes_ff, nbytes_in;
   logic               last_ff, last_in;
   logic [LEN_W-1:0]   len_ff, len_in;

   logic [WORD_W-1:0]  seed_ff, seed_in;
   logic [WORD_W-1:0]  hash_ff, hash_in;   // running hash before finalization
   logic [WORD_W-1:0]  k_ff, k_in;         // mixed key, or multiplied final hash
   logic [WORD_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_take;
   logic               rsp_free;
   logic               mul_run;
   logic [WORD_W-1:0]  mul_op;
   logic               mul_done;
   logic [WORD_W-1:0]  mul_res;
   mh64_state_type     route_state;

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .run     (mul_run),
      .operand (mul_op),
      .done    (mul_done),
      .result  (mul_res)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_take         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;
   assign csr_chan.ready   = 1'b1;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;

   // where a word goes once the initial value is in place
   always_comb begin
      priority if (nbytes_ff[3]) begin
         route_state = ST_K_MUL1;
      end else if (nbytes_ff[2:0] != 3'd0) begin
         route_state = ST_TAIL;
      end else if (last_ff) begin
         route_state = ST_FIN_MUL;
      end else begin
         route_state = ST_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_chan.first ? ST_LEN_MUL : ST_TAIL;
               // a non-first beat is routed straight from the req fields
               if (!req_chan.first) begin
                  priority if (req_chan.valid_bytes[3]) begin
                     state_in = ST_K_MUL1;
                  end else if (req_chan.valid_bytes[2:0] != 3'd0) begin
                     state_in = ST_TAIL;
                  end else if (req_chan.last) begin
                     state_in = ST_FIN_MUL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_LEN_MUL: if (mul_done) state_in = route_state;
         ST_K_MUL1:  if (mul_done) state_in = ST_K_MUL2;
         ST_K_MUL2:  if (mul_done) state_in = ST_H_MUL;
         ST_TAIL:    state_in = ST_H_MUL;
         ST_H_MUL:   if (mul_done) state_in = last_ff ? ST_FIN_MUL : ST_IDLE;
         ST_FIN_MUL: if (mul_done) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // multiplier control and datapath updates
   always_comb begin
      mul_run      = 1'b0;
      mul_op       = hash_ff;
      word_in      = word_ff;
      nbytes_in    = nbytes_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      k_in         = k_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      seed_in      = csr_chan.valid ? csr_chan.data : seed_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               word_in   = req_chan.data_word;
               nbytes_in = req_chan.valid_bytes;
               last_in   = req_chan.last;
               len_in    = req_chan.total_length;
            end
         end
         ST_LEN_MUL: begin
            mul_run = 1'b1;
            mul_op  = {{(WORD_W-LEN_W){1'b0}}, len_ff};
            if (mul_done) hash_in = seed_ff ^ mul_res;
         end
         ST_K_MUL1: begin
            mul_run = 1'b1;
            mul_op  = word_ff;
            if (mul_done) k_in = mul_res ^ (mul_res >> MIX_SHIFT);
         end
         ST_K_MUL2: begin
            mul_run = 1'b1;
            mul_op  = k_ff;
            if (mul_done) hash_in = hash_ff ^ mul_res;
         end
         ST_TAIL: begin
            hash_in = hash_ff ^ (word_ff & byte_mask(nbytes_ff[2:0]));
         end
         ST_H_MUL: begin
            mul_run = 1'b1;
            mul_op  = hash_ff;
            if (mul_done) hash_in = mul_res;
         end
         ST_FIN_MUL: begin
            mul_run = 1'b1;
            mul_op  = hash_ff ^ (hash_ff >> MIX_SHIFT);
            if (mul_done) k_in = mul_res;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_hash_in  = k_ff ^ (k_ff >> MIX_SHIFT);
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
         hash_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      nbytes_ff   <= nbytes_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/mh64_mul.sv
`default_nettype none
// operand * MIX_MUL mod 2^64 from three 32x32 partial products
module mh64_mul
   import mh64_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              run,
   input  wire logic [WORD_W-1:0] operand,
   output      logic              done,
   output      logic [WORD_W-1:0] result
);

   mh64_mstep_type    step_ff, step_in;
   logic [63:0]       prod_ff, prod_in;
   logic [63:0]       acc_ff, acc_in;
   logic [31:0]       a_sel, b_sel;
   logic [31:0]       hi_sum;

   assign hi_sum = acc_ff[63:32] + prod_ff[31:0];
   assign result = {hi_sum, acc_ff[31:0]};
   assign done   = run && (step_ff == MS_SUM);

   always_comb begin
      a_sel   = operand[31:0];
      b_sel   = MIX_MUL_LO;
      acc_in  = acc_ff;
      step_in = step_ff;
      unique case (step_ff)
         MS_LO_LO: begin
            if (run) step_in = MS_HI_LO;
         end
         MS_HI_LO: begin
            a_sel   = operand[63:32];
            acc_in  = prod_ff;
            step_in = MS_LO_HI;
         end
         MS_LO_HI: begin
            b_sel   = MIX_MUL_HI;
            acc_in  = {hi_sum, acc_ff[31:0]};
            step_in = MS_SUM;
         end
         MS_SUM: begin
            step_in = MS_LO_LO;
         end
         default: step_in = MS_LO_LO;
      endcase
      prod_in = 64'(a_sel) * 64'(b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MS_LO_LO;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/mh64_check.sv
`default_nettype none
module mh64_check
   import mh64_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [NBYTE_W-1:0] req_valid_bytes,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [WORD_W-1:0] rsp_hash_value,
   input wire logic              csr_ready
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("rsp beat dropped or changed while stalled");

   a_busy_on_full_word: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_valid_bytes[3] |=> !req_ready)
      else $error("req ready while mixing a full word");

   a_no_instant_hash: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("hash emitted one cycle after a req beat");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr channel not ready");

endmodule

bind murmur2_64bit_stream_hash mh64_check u_mh64_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_valid_bytes (req_chan.valid_bytes),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hash_value  (rsp_chan.hash_value),
   .csr_ready       (csr_chan.ready)
);
`default_nettype wire
